// File: sv/smpq_pkg.sv
// shared constants and types for the sorted max priority queue
`timescale 1ns / 1ps

package smpq_pkg;

	localparam int CAPACITY = 32;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int VAL_W    = 32;

	typedef enum logic {
		REQ_INSERT = 1'b0,
		REQ_REMOVE = 1'b1
	} req_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	// command broadcast to every cell
	typedef struct packed {
		logic                    ins;
		logic                    rem;
		logic signed [VAL_W-1:0] value;
	} cell_cmd_t;

	// what a cell shows its neighbors
	typedef struct packed {
		logic                    valid;
		logic                    keep;
		logic signed [VAL_W-1:0] value;
	} cell_link_t;

endpackage

// File: sv/smpq_cell.sv
// one slot of the sorted store, shifting toward or away from the head
`timescale 1ns / 1ps

module smpq_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  smpq_pkg::cell_cmd_t  cmd,
	input  smpq_pkg::cell_link_t from_prev,
	input  smpq_pkg::cell_link_t from_next,
	output smpq_pkg::cell_link_t link
);
	import smpq_pkg::*;

	logic                    valid_q;
	logic signed [VAL_W-1:0] value_q;
	logic                    keep;
	logic                    valid_d;
	logic signed [VAL_W-1:0] value_d;

	// stays put on insert when it holds a value >= the new one
	assign keep = valid_q && (value_q >= cmd.value);

	always_comb begin
		valid_d = valid_q;
		value_d = value_q;
		if (cmd.ins) begin
			if (!keep) begin
				if (from_prev.keep) begin
					valid_d = 1'b1;
					value_d = cmd.value;
				end else begin
					valid_d = from_prev.valid;
					value_d = from_prev.value;
				end
			end
		end else if (cmd.rem) begin
			valid_d = from_next.valid;
			value_d = from_next.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		value_q <= value_d;
	end

	assign link.valid = valid_q;
	assign link.keep  = keep;
	assign link.value = value_q;

endmodule

// File: sv/sorted_max_priority_queue_unit.sv
// Sorted max priority queue: a row of CAPACITY cells kept in descending signed order,
// largest at the head, equal values leaving in arrival order. Every request is one
// transfer in and one result out; each request is applied to all cells at once, so one
// request is taken every cycle while in_stall is low, and its result appears in the next cycle.
// The result sits in an output register; while that register holds a result
// that is stalled, in_stall is high and no new request is taken.
`timescale 1ns / 1ps

module sorted_max_priority_queue_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        req_type,
	input  logic signed [31:0]          value,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [31:0]          removed_value,
	output logic [1:0]                  status,
	output logic [5:0]                  item_count
);
	import smpq_pkg::*;

	logic                    in_xfer;
	logic                    is_remove;
	logic                    full;
	logic                    empty;
	logic [CNT_W-1:0]        occ_q;
	logic [CNT_W-1:0]        occ_d;
	logic [31:0]             occ_ext;
	cell_cmd_t               cmd;
	cell_link_t              links [CAPACITY];
	cell_link_t              head_prev;
	cell_link_t              tail_next;
	logic                    out_valid_q;
	logic signed [VAL_W-1:0] removed_q;
	status_t                 status_q;
	logic [5:0]              count_q;
	logic signed [VAL_W-1:0] removed_d;
	status_t                 status_d;

	assign in_stall  = out_valid_q && out_stall;
	assign in_xfer   = in_valid && !in_stall;
	assign is_remove = (req_t'(req_type) == REQ_REMOVE);
	assign full      = (occ_q == CNT_W'(CAPACITY));
	assign empty     = (occ_q == '0);

	assign cmd.ins   = in_xfer && !is_remove && !full;
	assign cmd.rem   = in_xfer && is_remove && !empty;
	assign cmd.value = value;

	// head sees a neighbor that always keeps, tail sees an empty slot
	assign head_prev.valid = 1'b0;
	assign head_prev.keep  = 1'b1;
	assign head_prev.value = '0;
	assign tail_next.valid = 1'b0;
	assign tail_next.keep  = 1'b0;
	assign tail_next.value = '0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		smpq_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.from_prev ((i == 0) ? head_prev : links[(i == 0) ? 0 : i - 1]),
			.from_next ((i == CAPACITY - 1) ? tail_next
			                                : links[(i == CAPACITY - 1) ? i : i + 1]),
			.link      (links[i])
		);
	end

	always_comb begin
		occ_d     = occ_q;
		removed_d = '0;
		status_d  = ST_OK;
		if (is_remove) begin
			if (empty) begin
				status_d = ST_UNDERFLOW;
			end else begin
				removed_d = links[0].value;
				occ_d     = occ_q - 1'b1;
			end
		end else begin
			if (full) begin
				status_d = ST_OVERFLOW;
			end else begin
				occ_d = occ_q + 1'b1;
			end
		end
	end

	assign occ_ext = 32'(occ_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_xfer) begin
				occ_q       <= occ_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			removed_q <= removed_d;
			status_q  <= status_d;
			count_q   <= occ_ext[5:0];
		end
	end

	assign out_valid     = out_valid_q;
	assign removed_value = removed_q;
	assign status        = status_q;
	assign item_count    = count_q;

endmodule

// File: sv/smpq_checker.sv
// port-level checks for the sorted max priority queue, bound to the top level
`timescale 1ns / 1ps

module smpq_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [31:0] removed_value,
	input logic [1:0]         status,
	input logic [5:0]         item_count
);
	import smpq_pkg::*;

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// every input transfer yields a result in the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> out_valid)
		else $error("no result after input transfer");

	a_underflow_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_UNDERFLOW |-> removed_value == 0 && item_count == 0)
		else $error("underflow with nonzero value or count");

	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_OVERFLOW |-> removed_value == 0
			&& item_count == 6'(CAPACITY))
		else $error("overflow while not full");

endmodule

bind sorted_max_priority_queue_unit smpq_checker u_smpq_checker (.*);
